### design/lsf_pkg.sv
// Shared constants, types and helpers for the largest square finder.
package lsf_pkg;

  localparam int MAX_COLS = 1024;
  localparam int MAX_ROWS = 1024;

  localparam int COL_W  = $clog2(MAX_COLS);
  localparam int ROW_W  = $clog2(MAX_ROWS);
  localparam int SIZE_W = 11;
  localparam int CFG_W  = 11;
  localparam int CFG_IDX_W = 1;

  localparam int IN_DATA_W  = 8;
  localparam int OUT_DATA_W = 32;

  // Register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_ROW_LENGTH = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ROW_COUNT  = 1'd1;

  typedef logic [SIZE_W-1:0] size_t;

  // One cell between the read issue and the update stage
  typedef struct packed {
    logic             free;
    logic             edge_cell;
    logic             last;
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
  } cell_t;

  function automatic size_t min3(size_t a, size_t b, size_t c);
    size_t m;
    m = a;
    if (b < m) m = b;
    if (c < m) m = c;
    return m;
  endfunction

endpackage

### design/lsf_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module lsf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
  end

  always_ff @(posedge clk) begin
    if (re) rdata <= mem[raddr];
  end

endmodule

### design/largest_square_finder.sv
// Top level: streamed maximal-square search over a binary grid.
//
//  channel | dir | handshake         | payload
//  in_     | in  | in_tvalid/tready  | tdata[0] cell_free
//  out_    | out | out_tvalid/tready | tdata[10:0] best_size, [20:11] best_row, [30:21] best_col
//  cfg_    | in  | cfg_we            | cfg_index, cfg_wdata (row_length, row_count)
//
// One cell per cycle sustained while in_tready stays high. A cell issues its line-buffer
// read on accept, waits in the s1 register for the registered read data, and is updated
// and written back when it fires; the result leaves through an output register loaded then.
// in_tready drops only while a finished result waits behind an undrained output.
// Reset is synchronous; the line buffer needs no clearing pass.
module largest_square_finder
  import lsf_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_tvalid,
  output logic                    in_tready,
  input  logic [IN_DATA_W-1:0]    in_tdata,   // [0] cell_free
  output logic                    out_tvalid,
  input  logic                    out_tready,
  output logic [OUT_DATA_W-1:0]   out_tdata,  // [10:0] best_size, [20:11] best_row,
                                              // [30:21] best_col
  input  logic                    cfg_we,
  input  logic [CFG_IDX_W-1:0]    cfg_index,
  input  logic [CFG_W-1:0]        cfg_wdata
);

  logic [COL_W-1:0] cols_last_r, cols_last_nxt;
  logic [ROW_W-1:0] rows_last_r, rows_last_nxt;
  logic [COL_W-1:0] col_r, col_nxt;
  logic [ROW_W-1:0] row_r, row_nxt;

  logic  s1_v_r, s1_v_nxt;
  cell_t s1_r, s1_nxt;

  size_t left_r, left_nxt;
  size_t diag_r, diag_nxt;
  size_t max_r, max_nxt;
  logic [ROW_W-1:0] max_row_r, max_row_nxt;
  logic [COL_W-1:0] max_col_r, max_col_nxt;

  logic                  out_v_r, out_v_nxt;
  logic [OUT_DATA_W-1:0] out_d_r, out_d_nxt;

  logic  in_fire, s1_hold, s1_fire;
  logic  col_end, row_end;
  size_t up;
  size_t size;
  size_t best;
  logic [ROW_W-1:0] best_row;
  logic [COL_W-1:0] best_col;

  function automatic logic [COL_W-1:0] clamp_last_col(logic [CFG_W-1:0] v);
    if (v == '0) return '0;
    if (v > CFG_W'(MAX_COLS)) return COL_W'(MAX_COLS - 1);
    return COL_W'(v - CFG_W'(1));
  endfunction

  function automatic logic [ROW_W-1:0] clamp_last_row(logic [CFG_W-1:0] v);
    if (v == '0) return '0;
    if (v > CFG_W'(MAX_ROWS)) return ROW_W'(MAX_ROWS - 1);
    return ROW_W'(v - CFG_W'(1));
  endfunction

  lsf_ram #(
    .WIDTH(SIZE_W),
    .DEPTH(MAX_COLS)
  ) u_line_buf (
    .clk  (clk),
    .we   (s1_fire),
    .waddr(s1_r.col),
    .wdata(size),
    .re   (in_fire),
    .raddr(col_r),
    .rdata(up)
  );

  // A last cell cannot retire while the previous result is still stuck
  assign s1_hold   = s1_v_r && s1_r.last && out_v_r && !out_tready;
  assign s1_fire   = s1_v_r && !s1_hold;
  assign in_tready = !s1_hold;
  assign in_fire   = in_tvalid && in_tready;

  assign col_end = (col_r == cols_last_r);
  assign row_end = (row_r == rows_last_r);

  always_comb begin
    if (!s1_r.free)          size = '0;
    else if (s1_r.edge_cell) size = SIZE_W'(1);
    else                     size = min3(left_r, up, diag_r) + SIZE_W'(1);
  end

  always_comb begin
    best     = max_r;
    best_row = max_row_r;
    best_col = max_col_r;
    if (size > max_r) begin
      best     = size;
      best_row = s1_r.row;
      best_col = s1_r.col;
    end
  end

  always_comb begin
    cols_last_nxt = cols_last_r;
    rows_last_nxt = rows_last_r;
    col_nxt       = col_r;
    row_nxt       = row_r;
    s1_v_nxt      = s1_v_r;
    s1_nxt        = s1_r;
    left_nxt      = left_r;
    diag_nxt      = diag_r;
    max_nxt       = max_r;
    max_row_nxt   = max_row_r;
    max_col_nxt   = max_col_r;
    out_v_nxt     = out_v_r;
    out_d_nxt     = out_d_r;

    if (out_v_r && out_tready) out_v_nxt = 1'b0;

    if (s1_fire) begin
      s1_v_nxt = 1'b0;
      left_nxt = size;
      diag_nxt = up;
      if (s1_r.last) begin
        out_v_nxt   = 1'b1;
        out_d_nxt   = {1'b0, best_col, best_row, best};
        max_nxt     = '0;
        max_row_nxt = '0;
        max_col_nxt = '0;
      end else begin
        max_nxt     = best;
        max_row_nxt = best_row;
        max_col_nxt = best_col;
      end
    end

    if (in_fire) begin
      s1_v_nxt         = 1'b1;
      s1_nxt.free      = in_tdata[0];
      s1_nxt.edge_cell = (row_r == '0) || (col_r == '0);
      s1_nxt.last      = col_end && row_end;
      s1_nxt.row       = row_r;
      s1_nxt.col       = col_r;
      if (col_end) begin
        col_nxt = '0;
        row_nxt = row_end ? '0 : row_r + ROW_W'(1);
      end else begin
        col_nxt = col_r + COL_W'(1);
      end
    end

    if (cfg_we) begin
      unique case (cfg_index)
        REG_ROW_LENGTH: cols_last_nxt = clamp_last_col(cfg_wdata);
        REG_ROW_COUNT:  rows_last_nxt = clamp_last_row(cfg_wdata);
        default: ;
      endcase
      // restart the scan
      col_nxt     = '0;
      row_nxt     = '0;
      s1_v_nxt    = 1'b0;
      left_nxt    = '0;
      diag_nxt    = '0;
      max_nxt     = '0;
      max_row_nxt = '0;
      max_col_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cols_last_r <= COL_W'(MAX_COLS - 1);
      rows_last_r <= ROW_W'(MAX_ROWS - 1);
      col_r       <= '0;
      row_r       <= '0;
      s1_v_r      <= 1'b0;
      left_r      <= '0;
      diag_r      <= '0;
      max_r       <= '0;
      max_row_r   <= '0;
      max_col_r   <= '0;
      out_v_r     <= 1'b0;
    end else begin
      cols_last_r <= cols_last_nxt;
      rows_last_r <= rows_last_nxt;
      col_r       <= col_nxt;
      row_r       <= row_nxt;
      s1_v_r      <= s1_v_nxt;
      left_r      <= left_nxt;
      diag_r      <= diag_nxt;
      max_r       <= max_nxt;
      max_row_r   <= max_row_nxt;
      max_col_r   <= max_col_nxt;
      out_v_r     <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    s1_r    <= s1_nxt;
    out_d_r <= out_d_nxt;
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = out_d_r;

endmodule

### design/lsf_checker.sv
// Port-level checker for the largest square finder, bound to the top level.
module lsf_checker
  import lsf_pkg::*;
(
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_tvalid,
  input logic                  in_tready,
  input logic [IN_DATA_W-1:0]  in_tdata,
  input logic                  out_tvalid,
  input logic                  out_tready,
  input logic [OUT_DATA_W-1:0] out_tdata,
  input logic                  cfg_we,
  input logic [CFG_IDX_W-1:0]  cfg_index,
  input logic [CFG_W-1:0]      cfg_wdata
);

  logic [SIZE_W-1:0] sz;
  logic [ROW_W-1:0]  rw;
  logic [COL_W-1:0]  cl;

  assign sz = out_tdata[SIZE_W-1:0];
  assign rw = out_tdata[SIZE_W+ROW_W-1:SIZE_W];
  assign cl = out_tdata[SIZE_W+ROW_W+COL_W-1:SIZE_W+ROW_W];

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  // a fresh result is always preceded by an accepted item
  a_out_cause: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(in_tvalid && in_tready, 2))
    else $error("result without a causing item");

  // the reported square fits inside the grid from its bottom-right corner
  a_square_fits: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> ({1'b0, rw} + 11'd1 >= sz) && ({1'b0, cl} + 11'd1 >= sz))
    else $error("square does not fit its corner");

  a_reset_clear: assert property (@(posedge clk)
    $past(!rst_n) |-> !out_tvalid)
    else $error("result valid after reset");

  // offered items and register writes carry known values
  a_known: assert property (@(posedge clk) disable iff (!rst_n)
    (!in_tvalid || !$isunknown(in_tdata)) &&
    (!cfg_we || !$isunknown({cfg_index, cfg_wdata})))
    else $error("unknown value on an offered item or write");

endmodule

bind largest_square_finder lsf_checker u_lsf_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_tvalid (in_tvalid),
  .in_tready (in_tready),
  .in_tdata  (in_tdata),
  .out_tvalid(out_tvalid),
  .out_tready(out_tready),
  .out_tdata (out_tdata),
  .cfg_we    (cfg_we),
  .cfg_index (cfg_index),
  .cfg_wdata (cfg_wdata)
);
